// ----- hdl/jsu_pkg.sv -----
`timescale 1ns / 1ps
// Package for the JSON string unescaper: item types, status and format codes,
// character constants and the code point to output unit encoder. No dependencies.
package jsu_pkg;

   localparam int CpWidth = 21;

   typedef struct packed {
      logic       start_req;
      logic       end_of_input;
      logic [7:0] byte_req;
   } jsu_req_type;

   typedef struct packed {
      logic [CpWidth-1:0] code_unit;
      logic               has_unit;
      logic [2:0]         status;
      logic               last;
   } jsu_rsp_type;

   // status codes
   localparam logic [2:0] ST_RUNNING  = 3'd0;
   localparam logic [2:0] ST_CLOSED   = 3'd1;
   localparam logic [2:0] ST_CTRL     = 3'd2;
   localparam logic [2:0] ST_NO_QUOTE = 3'd3;
   localparam logic [2:0] ST_BAD_ESC  = 3'd4;
   localparam logic [2:0] ST_BAD_HEX  = 3'd5;

   // output format codes; the unused code behaves as UTF-32
   localparam logic [1:0] FMT_UTF8   = 2'd0;
   localparam logic [1:0] FMT_UTF16  = 2'd1;
   localparam logic [1:0] FMT_UTF32  = 2'd2;
   localparam logic [1:0] FMT_RESET  = FMT_UTF16;

   localparam int MaxResults = 6;

   // characters
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6E;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   // surrogate ranges
   localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
   localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
   localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
   localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
   localparam logic [CpWidth-1:0] SUPP_BASE = 21'h10000;

   typedef struct packed {
      logic [3:0][CpWidth-1:0] unit;
      logic [2:0]              count;
   } jsu_enc_type;

   // Encode one code point; raw bytes pass through as one unit of their value.
   function automatic jsu_enc_type jsu_encode(input logic [CpWidth-1:0] cp,
                                              input logic raw,
                                              input logic [1:0] fmt);
      jsu_enc_type        enc;
      logic [CpWidth-1:0] v;
      enc = '0;
      v   = cp - SUPP_BASE;
      enc.unit[0] = cp;
      enc.count   = 3'd1;
      if (!raw && fmt == FMT_UTF8) begin
         if (cp <= 21'h7F) begin
            enc.unit[0] = cp;
         end else if (cp <= 21'h7FF) begin
            enc.unit[0] = {13'd0, 3'b110, cp[10:6]};
            enc.unit[1] = {13'd0, 2'b10, cp[5:0]};
            enc.count   = 3'd2;
         end else if (cp <= 21'hFFFF) begin
            enc.unit[0] = {13'd0, 4'b1110, cp[15:12]};
            enc.unit[1] = {13'd0, 2'b10, cp[11:6]};
            enc.unit[2] = {13'd0, 2'b10, cp[5:0]};
            enc.count   = 3'd3;
         end else begin
            enc.unit[0] = {13'd0, 5'b11110, cp[20:18]};
            enc.unit[1] = {13'd0, 2'b10, cp[17:12]};
            enc.unit[2] = {13'd0, 2'b10, cp[11:6]};
            enc.unit[3] = {13'd0, 2'b10, cp[5:0]};
            enc.count   = 3'd4;
         end
      end else if (!raw && fmt == FMT_UTF16 && cp >= SUPP_BASE) begin
         enc.unit[0] = {5'd0, HIGH_SURR_LO + {6'd0, v[19:10]}};
         enc.unit[1] = {5'd0, LOW_SURR_LO + {6'd0, v[9:0]}};
         enc.count   = 3'd2;
      end
      return enc;
   endfunction

endpackage

// ----- hdl/json_string_unescaper.sv -----
`timescale 1ns / 1ps
// JSON string unescaper: byte in, UTF-8 / UTF-16 / UTF-32 units out.
// Latency: the first result of an item is shown the cycle after it is accepted.
// Throughput: one byte per cycle while each byte yields at most one result and
// the result side does not stall; a byte that yields more than one result (up to
// six) holds the input stalled until its results drain. The next byte is taken as
// the last result leaves. Synchronous active-high reset: format UTF-16, decoder cleared.
module json_string_unescaper (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  jsu_pkg::jsu_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output jsu_pkg::jsu_rsp_type rsp_payload,
   input  logic                 csr_wr_en,
   input  logic [1:0]           csr_wr_data
);
   import jsu_pkg::*;

   typedef enum logic [2:0] {
      PH_TEXT, PH_ESC, PH_HEX, PH_LOOK_BS, PH_LOOK_U
   } phase_type;

   phase_type   phase_ff, phase_in, ph_cur;
   logic [11:0] hex_ff, hex_in, hex_cur;
   logic [1:0]  hcnt_ff, hcnt_in, hcnt_cur;
   logic [9:0]  held_ff, held_in, held_cur;
   logic        second_ff, second_in, second_cur;
   logic        stopped_ff, stopped_in, stopped_cur;
   logic [1:0]  fmt_ff;

   jsu_rsp_type [MaxResults-1:0] buf_ff, buf_in;
   logic [2:0]  cnt_ff;

   logic        req_acc, rsp_acc;
   logic [7:0]  b;
   logic        eoi;

   // text and escape byte classification
   logic        t_close, t_ctrl, t_bs;
   logic        e_ok, e_u;
   logic [7:0]  e_val;
   logic        h_ok;
   logic [3:0]  h_dig;
   logic [15:0] num;
   logic        num_high, num_low;

   logic              cp0_v, cp1_v, cp1_raw;
   logic [CpWidth-1:0] cp0, cp1;
   logic [2:0]        st;
   jsu_enc_type       enc0, enc1;
   logic [2:0]        n0, n1;
   logic [3:0]        ntot;
   logic [2:0]        nres;
   logic [3:0]        k;

   assign b   = req_payload.byte_req;
   assign eoi = req_payload.end_of_input;

   assign rsp_valid   = cnt_ff != 3'd0;
   assign rsp_payload = buf_ff[0];
   assign req_stall   = (cnt_ff > 3'd1) || (cnt_ff == 3'd1 && rsp_stall);
   assign req_acc     = req_valid && !req_stall;
   assign rsp_acc     = rsp_valid && !rsp_stall;

   assign t_close = b == CH_QUOTE;
   assign t_ctrl  = b < CH_SPACE || b == CH_DEL;
   assign t_bs    = b == CH_BSLASH;

   always_comb begin
      e_ok  = 1'b1;
      e_u   = 1'b0;
      e_val = b;
      unique case (b) inside
         CH_QUOTE, CH_BSLASH, CH_SLASH: e_val = b;
         CH_B: e_val = 8'h08;
         CH_F: e_val = 8'h0C;
         CH_N: e_val = 8'h0A;
         CH_R: e_val = 8'h0D;
         CH_T: e_val = 8'h09;
         CH_U: begin
            e_ok = 1'b0;
            e_u  = 1'b1;
         end
         default: e_ok = 1'b0;
      endcase
   end

   always_comb begin
      h_ok  = 1'b1;
      h_dig = 4'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         h_dig = 4'(b - 8'h30);
      end else if (b >= 8'h61 && b <= 8'h66) begin
         h_dig = 4'(b - 8'h57);
      end else if (b >= 8'h41 && b <= 8'h46) begin
         h_dig = 4'(b - 8'h37);
      end else begin
         h_ok = 1'b0;
      end
   end

   always_comb begin
      // start clears the decoder before this byte is handled
      ph_cur      = req_payload.start_req ? PH_TEXT : phase_ff;
      hex_cur     = req_payload.start_req ? 12'd0 : hex_ff;
      hcnt_cur    = req_payload.start_req ? 2'd0 : hcnt_ff;
      held_cur    = req_payload.start_req ? 10'd0 : held_ff;
      second_cur  = req_payload.start_req ? 1'b0 : second_ff;
      stopped_cur = req_payload.start_req ? 1'b0 : stopped_ff;
   end

   assign num      = {hex_cur, h_dig};
   assign num_high = num >= HIGH_SURR_LO && num <= HIGH_SURR_HI;
   assign num_low  = num >= LOW_SURR_LO && num <= LOW_SURR_HI;

   always_comb begin
      phase_in   = ph_cur;
      hex_in     = hex_cur;
      hcnt_in    = hcnt_cur;
      held_in    = held_cur;
      second_in  = second_cur;
      stopped_in = stopped_cur;
      cp0_v      = 1'b0;
      cp0        = {5'd0, HIGH_SURR_TAG, held_cur};
      cp1_v      = 1'b0;
      cp1_raw    = 1'b0;
      cp1        = 21'(b);
      st         = ST_RUNNING;
      if (!stopped_cur) begin
         unique case (ph_cur) inside
            PH_TEXT, PH_LOOK_BS: begin
               if (ph_cur == PH_LOOK_BS && !eoi && t_bs) begin
                  phase_in = PH_LOOK_U;
               end else begin
                  phase_in = PH_TEXT;
                  if (ph_cur == PH_LOOK_BS) begin
                     cp0_v   = 1'b1;
                     held_in = 10'd0;
                  end
                  if (eoi) st = ST_NO_QUOTE;
                  else if (t_close) st = ST_CLOSED;
                  else if (t_ctrl) st = ST_CTRL;
                  else if (t_bs) phase_in = PH_ESC;
                  else begin
                     cp1_v   = 1'b1;
                     cp1_raw = b[7];
                  end
               end
            end
            PH_ESC, PH_LOOK_U: begin
               if (ph_cur == PH_LOOK_U && !eoi && b == CH_U) begin
                  phase_in  = PH_HEX;
                  hex_in    = 12'd0;
                  hcnt_in   = 2'd0;
                  second_in = 1'b1;
               end else begin
                  phase_in = PH_TEXT;
                  if (ph_cur == PH_LOOK_U) begin
                     cp0_v   = 1'b1;
                     held_in = 10'd0;
                  end
                  if (eoi) st = ST_BAD_ESC;
                  else if (e_u) begin
                     phase_in  = PH_HEX;
                     hex_in    = 12'd0;
                     hcnt_in   = 2'd0;
                     second_in = 1'b0;
                  end else if (e_ok) begin
                     cp1_v = 1'b1;
                     cp1   = 21'(e_val);
                  end else st = ST_BAD_ESC;
               end
            end
            PH_HEX: begin
               if (eoi || !h_ok) begin
                  st = ST_BAD_HEX;
               end else if (hcnt_cur != 2'd3) begin
                  hex_in  = num[11:0];
                  hcnt_in = hcnt_cur + 2'd1;
               end else begin
                  hex_in   = 12'd0;
                  hcnt_in  = 2'd0;
                  phase_in = PH_TEXT;
                  cp1      = {5'd0, num};
                  if (!second_cur) begin
                     if (num_high) begin
                        held_in  = num[9:0];
                        phase_in = PH_LOOK_BS;
                     end else begin
                        cp1_v = 1'b1;
                     end
                  end else begin
                     second_in = 1'b0;
                     held_in   = 10'd0;
                     cp1_v     = 1'b1;
                     if (num_low) begin
                        cp1 = SUPP_BASE + {1'b0, held_cur, num[9:0]};
                     end else begin
                        cp0_v = 1'b1;
                     end
                  end
               end
            end
            default: phase_in = PH_TEXT;
         endcase
         if (st != ST_RUNNING) begin
            stopped_in = 1'b1;
            phase_in   = PH_TEXT;
         end
      end
   end

   // lay out the item's results: units of cp0, units of cp1, then status
   always_comb begin
      enc0 = jsu_encode(cp0, 1'b0, fmt_ff);
      enc1 = jsu_encode(cp1, cp1_raw, fmt_ff);
      n0   = cp0_v ? enc0.count : 3'd0;
      n1   = cp1_v ? enc1.count : 3'd0;
      ntot = {1'b0, n0} + {1'b0, n1} + {3'd0, st != ST_RUNNING};
      nres = (ntot > 4'(MaxResults)) ? 3'(MaxResults) : ntot[2:0];
      k    = 4'd0;
      for (int i = 0; i < MaxResults; i++) begin
         buf_in[i] = '0;
         k = 4'(i) - {1'b0, n0};
         if (4'(i) < {1'b0, n0}) begin
            buf_in[i].code_unit = enc0.unit[i[1:0]];
            buf_in[i].has_unit  = 1'b1;
         end else if (4'(i) < {1'b0, n0} + {1'b0, n1}) begin
            buf_in[i].code_unit = enc1.unit[k[1:0]];
            buf_in[i].has_unit  = 1'b1;
         end else begin
            buf_in[i].status = st;
         end
         buf_in[i].last = (4'(i) + 4'd1) == {1'b0, nres};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_TEXT;
         hex_ff     <= '0;
         hcnt_ff    <= '0;
         held_ff    <= '0;
         second_ff  <= 1'b0;
         stopped_ff <= 1'b0;
         fmt_ff     <= FMT_RESET;
         cnt_ff     <= '0;
      end else begin
         if (csr_wr_en) fmt_ff <= csr_wr_data;
         if (req_acc) begin
            phase_ff   <= phase_in;
            hex_ff     <= hex_in;
            hcnt_ff    <= hcnt_in;
            held_ff    <= held_in;
            second_ff  <= second_in;
            stopped_ff <= stopped_in;
            cnt_ff     <= nres;
         end else if (rsp_acc) begin
            cnt_ff <= cnt_ff - 3'd1;
         end
      end
      // result buffer payload
      if (req_acc) begin
         buf_ff <= buf_in;
      end else if (rsp_acc) begin
         for (int i = 0; i < MaxResults - 1; i++) buf_ff[i] <= buf_ff[i+1];
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 3'(MaxResults))
      else $error("result count out of range");
   a_last_single: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 3'd1 |-> buf_ff[0].last)
      else $error("final buffered result lacks last");
   a_last_early: assert property (@(posedge clock) disable iff (reset)
      cnt_ff > 3'd1 |-> !buf_ff[0].last)
      else $error("last shown before item's final result");
   a_stopped_quiet: assert property (@(posedge clock) disable iff (reset)
      req_acc && stopped_ff && !req_payload.start_req |=> cnt_ff == 3'd0)
      else $error("results produced after stop");
   a_status_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.has_unit |-> rsp_payload.status != ST_RUNNING)
      else $error("empty result without status");

endmodule
